// ----- design/owb_pkg.sv -----
// Shared types, codes and reset values for the 1-Wire bus master.
`default_nettype none

package owb_pkg;

    localparam int BITS_PER_TRANSFER_DEF = 8;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // operation codes carried in the op field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_REC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PHASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PHASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_REC     = 3'd7;

    // register reset values
    localparam logic [CFG_W-1:0] RESET_LOW_DEF     = 16'd600;
    localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF = 16'd100;
    localparam logic [CFG_W-1:0] RESET_REC_DEF     = 16'd500;
    localparam logic [CFG_W-1:0] SHORT_PHASE_DEF   = 16'd3;
    localparam logic [CFG_W-1:0] LONG_PHASE_DEF    = 16'd90;
    localparam logic [CFG_W-1:0] READ_LOW_DEF      = 16'd2;
    localparam logic [CFG_W-1:0] READ_SAMPLE_DEF   = 16'd10;
    localparam logic [CFG_W-1:0] READ_REC_DEF      = 16'd58;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_REC  = 4'd3,
        PH_W_FIRST  = 4'd4,
        PH_W_SECOND = 4'd5,
        PH_R_LOW    = 4'd6,
        PH_R_WAIT   = 4'd7,
        PH_R_REC    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_recovery_ticks;
        logic [CFG_W-1:0] short_phase_ticks;
        logic [CFG_W-1:0] long_phase_ticks;
        logic [CFG_W-1:0] read_low_ticks;
        logic [CFG_W-1:0] read_sample_ticks;
        logic [CFG_W-1:0] read_recovery_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       line_in;
    } t_item;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_byte;
        logic       rejected;
    } t_result;

endpackage

`default_nettype wire

// ----- design/owb_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per transfer.
`default_nettype none

interface owb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/owb_core.sv -----
// Bus sequencer: phase state, slot counter, shift register and config registers.
`default_nettype none

module owb_core #(
    parameter int BITS_PER_TRANSFER = owb_pkg::BITS_PER_TRANSFER_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [owb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [owb_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire                              i_step,
    input  wire owb_pkg::t_item              i_item,
    output owb_pkg::t_result                 o_res
);

    localparam logic [2:0] LAST_IDX = 3'(BITS_PER_TRANSFER - 1);

    owb_pkg::t_cfg   r_cfg;
    owb_pkg::t_phase r_phase, n_phase;
    logic [owb_pkg::CFG_W-1:0] r_cnt, n_cnt, cnt_dec, raw_len;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift, r_last_rx, n_last_rx;
    logic r_presence, n_presence;
    logic is_tick, busy, expire, start, last_bit, done, rejected, load;

    assign is_tick  = (i_item.op == owb_pkg::OP_TICK);
    assign busy     = (r_phase != owb_pkg::PH_IDLE);
    assign cnt_dec  = (r_cnt != '0) ? r_cnt - 16'd1 : r_cnt;
    assign expire   = is_tick && busy && (cnt_dec == '0);
    assign start    = !is_tick && !busy;
    assign rejected = !is_tick && busy;
    assign last_bit = (r_bit >= LAST_IDX);
    assign load     = start || expire;

    // next phase
    always_comb begin
        n_phase = r_phase;
        done    = 1'b0;
        if (start) begin
            case (i_item.op)
                owb_pkg::OP_RESET: n_phase = owb_pkg::PH_RST_LOW;
                owb_pkg::OP_WRITE: n_phase = owb_pkg::PH_W_FIRST;
                default:           n_phase = owb_pkg::PH_R_LOW;
            endcase
        end else if (expire) begin
            case (r_phase)
                owb_pkg::PH_RST_LOW:  n_phase = owb_pkg::PH_RST_WAIT;
                owb_pkg::PH_RST_WAIT: n_phase = owb_pkg::PH_RST_REC;
                owb_pkg::PH_W_FIRST:  n_phase = owb_pkg::PH_W_SECOND;
                owb_pkg::PH_W_SECOND: begin
                    n_phase = last_bit ? owb_pkg::PH_IDLE : owb_pkg::PH_W_FIRST;
                    done    = last_bit;
                end
                owb_pkg::PH_R_LOW:    n_phase = owb_pkg::PH_R_WAIT;
                owb_pkg::PH_R_WAIT:   n_phase = owb_pkg::PH_R_REC;
                owb_pkg::PH_R_REC: begin
                    n_phase = last_bit ? owb_pkg::PH_IDLE : owb_pkg::PH_R_LOW;
                    done    = last_bit;
                end
                default: begin
                    // reset recovery ends the reset operation
                    n_phase = owb_pkg::PH_IDLE;
                    done    = 1'b1;
                end
            endcase
        end
    end

    // datapath next values
    always_comb begin
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_last_rx  = r_last_rx;
        if (start) begin
            n_bit = '0;
            if (i_item.op == owb_pkg::OP_WRITE) begin
                n_shift = i_item.tx_byte;
            end else if (i_item.op == owb_pkg::OP_READ) begin
                n_shift = '0;
            end
        end else if (expire) begin
            case (r_phase)
                owb_pkg::PH_RST_WAIT: n_presence = !i_item.line_in;
                owb_pkg::PH_R_WAIT: begin
                    if (i_item.line_in) begin
                        n_shift[r_bit] = 1'b1;
                    end
                end
                owb_pkg::PH_W_SECOND: begin
                    if (!last_bit) begin
                        n_bit = r_bit + 3'd1;
                    end
                end
                owb_pkg::PH_R_REC: begin
                    if (last_bit) begin
                        n_last_rx = r_shift;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
                default: n_bit = r_bit;
            endcase
        end
    end

    // length of the phase being entered; write slots pick by the bit about to go out
    always_comb begin
        case (n_phase)
            owb_pkg::PH_RST_LOW:  raw_len = r_cfg.reset_low_ticks;
            owb_pkg::PH_RST_WAIT: raw_len = r_cfg.presence_wait_ticks;
            owb_pkg::PH_RST_REC:  raw_len = r_cfg.reset_recovery_ticks;
            owb_pkg::PH_W_FIRST:  raw_len = n_shift[n_bit] ? r_cfg.short_phase_ticks
                                                           : r_cfg.long_phase_ticks;
            owb_pkg::PH_W_SECOND: raw_len = n_shift[n_bit] ? r_cfg.long_phase_ticks
                                                           : r_cfg.short_phase_ticks;
            owb_pkg::PH_R_LOW:    raw_len = r_cfg.read_low_ticks;
            owb_pkg::PH_R_WAIT:   raw_len = r_cfg.read_sample_ticks;
            owb_pkg::PH_R_REC:    raw_len = r_cfg.read_recovery_ticks;
            default:              raw_len = '0;
        endcase
        if (load) begin
            if (n_phase != owb_pkg::PH_IDLE && raw_len == '0) begin
                n_cnt = 16'd1;
            end else begin
                n_cnt = raw_len;
            end
        end else if (is_tick && busy) begin
            n_cnt = cnt_dec;
        end else begin
            n_cnt = r_cnt;
        end
    end

    // result of this item
    always_comb begin
        o_res.drive_low = (n_phase == owb_pkg::PH_RST_LOW) ||
                          (n_phase == owb_pkg::PH_W_FIRST) ||
                          (n_phase == owb_pkg::PH_R_LOW);
        o_res.busy_res  = (n_phase != owb_pkg::PH_IDLE);
        o_res.done_res  = done;
        o_res.presence  = n_presence;
        o_res.rx_byte   = n_last_rx;
        o_res.rejected  = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= owb_pkg::PH_IDLE;
            r_cnt      <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_last_rx  <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_last_rx  <= n_last_rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_ticks      <= owb_pkg::RESET_LOW_DEF;
            r_cfg.presence_wait_ticks  <= owb_pkg::PRESENCE_WAIT_DEF;
            r_cfg.reset_recovery_ticks <= owb_pkg::RESET_REC_DEF;
            r_cfg.short_phase_ticks    <= owb_pkg::SHORT_PHASE_DEF;
            r_cfg.long_phase_ticks     <= owb_pkg::LONG_PHASE_DEF;
            r_cfg.read_low_ticks       <= owb_pkg::READ_LOW_DEF;
            r_cfg.read_sample_ticks    <= owb_pkg::READ_SAMPLE_DEF;
            r_cfg.read_recovery_ticks  <= owb_pkg::READ_REC_DEF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                owb_pkg::REG_RESET_LOW:     r_cfg.reset_low_ticks      <= i_cfg_data;
                owb_pkg::REG_PRESENCE_WAIT: r_cfg.presence_wait_ticks  <= i_cfg_data;
                owb_pkg::REG_RESET_REC:     r_cfg.reset_recovery_ticks <= i_cfg_data;
                owb_pkg::REG_SHORT_PHASE:   r_cfg.short_phase_ticks    <= i_cfg_data;
                owb_pkg::REG_LONG_PHASE:    r_cfg.long_phase_ticks     <= i_cfg_data;
                owb_pkg::REG_READ_LOW:      r_cfg.read_low_ticks       <= i_cfg_data;
                owb_pkg::REG_READ_SAMPLE:   r_cfg.read_sample_ticks    <= i_cfg_data;
                owb_pkg::REG_READ_REC:      r_cfg.read_recovery_ticks  <= i_cfg_data;
                default:                    r_cfg.reset_low_ticks      <= r_cfg.reset_low_ticks;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/onewire_bus_master_top.sv -----
// 1-Wire bus master: input register, bus sequencer and result register.
//
// Each input transfer is one microsecond tick or a start command (bus reset,
// byte write, byte read); each one yields exactly one result transfer with the
// line drive, busy/done flags, presence, last read byte and a reject flag for a
// start that arrives while an operation runs. Throughput is one item per clock
// while the result side accepts: an item waits in the input register until the
// output register can take its result; the sequencer updates its phase, slot
// counter and shift register at the same edge as that result is captured, and
// result valid rises once it is in the output register. Slot lengths come from
// eight 16-bit registers written through the config port; they are to be
// written only while the block is idle, which the block itself does not enforce.
`default_nettype none

module onewire_bus_master_top #(
    parameter int BITS_PER_TRANSFER = owb_pkg::BITS_PER_TRANSFER_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [owb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [owb_pkg::CFG_W-1:0]     i_cfg_data,
    owb_stream_if.sink                   i_item,
    owb_stream_if.source                 o_result
);

    logic             r_in_valid;
    owb_pkg::t_item   r_in_item;
    logic             r_out_valid;
    owb_pkg::t_result r_out_res;
    owb_pkg::t_result core_res;
    logic             advance;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_res;

    owb_core #(
        .BITS_PER_TRANSFER (BITS_PER_TRANSFER)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (advance),
        .i_item     (r_in_item),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_item <= i_item.data;
        end
        if (advance) begin
            r_out_res <= core_res;
        end
    end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the 1-Wire bus master: directed rows, then random bus operations.
`default_nettype none

module testbench;

    import owb_pkg::*;

    localparam int CLK_PERIOD         = 8;
    localparam int RESET_CYCLES       = 11;
    localparam int ITEMS_PER_PHASE    = 175;
    localparam int PRINT_CAP          = 100;
    localparam int NUM_REGS           = 8;
    localparam int DIR_ROWS           = 14;

    // how a directed row runs its operation out once started
    typedef enum int {RUN_NONE, RUN_LOW, RUN_HIGH, RUN_RAND} run_mode_t;

    typedef struct {
        bit          reload;      // reload every register with reload_val first
        logic [15:0] reload_val;
        t_item       item;
        run_mode_t   run;
        bit          known;       // want holds the expected result
        t_result     want;
    } dir_row_t;

    localparam t_result RES_IDLE  = '0;
    localparam t_result RES_START = '{drive_low: 1'b1, busy_res: 1'b1, default: '0};
    localparam t_result RES_REJ   = '{drive_low: 1'b1, busy_res: 1'b1, rejected: 1'b1,
                                      default: '0};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    owb_stream_if #(.T(t_item))   item_ch ();
    owb_stream_if #(.T(t_result)) result_ch ();

    onewire_bus_master_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (item_ch),
        .o_result   (result_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // bus sequencer mirror
    logic [15:0] slot_len [NUM_REGS];
    t_phase      bus_phase;
    logic [15:0] ticks_left;
    logic [2:0]  bit_pos;
    logic [7:0]  shift_q;
    logic        presence_q;
    logic        drive_q;
    logic [7:0]  rx_last;

    t_result     pending_results [$];
    logic [15:0] cfg_plan [NUM_REGS];
    dir_row_t    dir_rows [DIR_ROWS];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int err_count       = 0;
    int items_counted   = 0;
    int results_seen    = 0;
    int ops_done        = 0;
    int starts_rejected = 0;

    task automatic flag_error(input string msg);
        if (err_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic void reset_model();
        slot_len[REG_RESET_LOW]     = RESET_LOW_DEF;
        slot_len[REG_PRESENCE_WAIT] = PRESENCE_WAIT_DEF;
        slot_len[REG_RESET_REC]     = RESET_REC_DEF;
        slot_len[REG_SHORT_PHASE]   = SHORT_PHASE_DEF;
        slot_len[REG_LONG_PHASE]    = LONG_PHASE_DEF;
        slot_len[REG_READ_LOW]      = READ_LOW_DEF;
        slot_len[REG_READ_SAMPLE]   = READ_SAMPLE_DEF;
        slot_len[REG_READ_REC]      = READ_REC_DEF;
        bus_phase  = PH_IDLE;
        ticks_left = '0;
        bit_pos    = '0;
        shift_q    = '0;
        presence_q = 1'b0;
        drive_q    = 1'b0;
        rx_last    = '0;
    endfunction

    function automatic void enter_phase(input t_phase p);
        logic [15:0] len;
        logic        drv;
        drv = 1'b0;
        case (p)
            PH_RST_LOW: begin
                len = slot_len[REG_RESET_LOW];
                drv = 1'b1;
            end
            PH_RST_WAIT: len = slot_len[REG_PRESENCE_WAIT];
            PH_RST_REC:  len = slot_len[REG_RESET_REC];
            PH_W_FIRST: begin
                len = shift_q[bit_pos] ? slot_len[REG_SHORT_PHASE] : slot_len[REG_LONG_PHASE];
                drv = 1'b1;
            end
            PH_W_SECOND: len = shift_q[bit_pos] ? slot_len[REG_LONG_PHASE]
                                                : slot_len[REG_SHORT_PHASE];
            PH_R_LOW: begin
                len = slot_len[REG_READ_LOW];
                drv = 1'b1;
            end
            PH_R_WAIT: len = slot_len[REG_READ_SAMPLE];
            PH_R_REC:  len = slot_len[REG_READ_REC];
            default:   len = '0;
        endcase
        // a zero length still lasts one tick
        if (p != PH_IDLE && len == '0)
            len = 16'd1;
        bus_phase  = p;
        ticks_left = len;
        drive_q    = drv;
    endfunction

    // one microsecond tick; returns 1 when the running operation finishes
    function automatic logic advance_tick(input logic line);
        logic last_bit;
        last_bit = (int'(bit_pos) >= BITS_PER_TRANSFER_DEF - 1);
        if (bus_phase == PH_IDLE)
            return 1'b0;
        if (ticks_left != '0)
            ticks_left--;
        if (ticks_left != '0)
            return 1'b0;
        case (bus_phase)
            PH_RST_LOW: enter_phase(PH_RST_WAIT);
            PH_RST_WAIT: begin
                presence_q = ~line;
                enter_phase(PH_RST_REC);
            end
            PH_W_FIRST: enter_phase(PH_W_SECOND);
            PH_W_SECOND: begin
                if (last_bit) begin
                    enter_phase(PH_IDLE);
                    return 1'b1;
                end
                bit_pos++;
                enter_phase(PH_W_FIRST);
            end
            PH_R_LOW: enter_phase(PH_R_WAIT);
            PH_R_WAIT: begin
                if (line)
                    shift_q[bit_pos] = 1'b1;
                enter_phase(PH_R_REC);
            end
            PH_R_REC: begin
                if (last_bit) begin
                    rx_last = shift_q;
                    enter_phase(PH_IDLE);
                    return 1'b1;
                end
                bit_pos++;
                enter_phase(PH_R_LOW);
            end
            default: begin
                // end of reset recovery
                enter_phase(PH_IDLE);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_result predict_result(input t_item it);
        t_result r;
        logic    done;
        logic    rej;
        done = 1'b0;
        rej  = 1'b0;
        if (it.op == OP_TICK) begin
            done = advance_tick(it.line_in);
        end else if (bus_phase != PH_IDLE) begin
            rej = 1'b1;
        end else begin
            bit_pos = '0;
            case (it.op)
                OP_RESET: enter_phase(PH_RST_LOW);
                OP_WRITE: begin
                    shift_q = it.tx_byte;
                    enter_phase(PH_W_FIRST);
                end
                OP_READ: begin
                    shift_q = '0;
                    enter_phase(PH_R_LOW);
                end
                default: ;
            endcase
        end
        r.drive_low = drive_q;
        r.busy_res  = (bus_phase != PH_IDLE);
        r.done_res  = done;
        r.presence  = presence_q;
        r.rx_byte   = rx_last;
        r.rejected  = rej;
        return r;
    endfunction

    // one item transfer with random sender gaps; the typed result replaces the
    // predicted one when given
    task automatic push_item(input t_item it, input bit use_want, input t_result want);
        t_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        if (it.op != OP_TICK || bus_phase != PH_IDLE)
            items_counted++;
        predicted = predict_result(it);
        pending_results.push_back(use_want ? want : predicted);
    endtask

    task automatic push_tick(input logic line);
        t_item it;
        it.op      = OP_TICK;
        it.tx_byte = 8'($urandom_range(255));
        it.line_in = line;
        push_item(it, 1'b0, RES_IDLE);
    endtask

    task automatic run_out(input run_mode_t mode);
        logic line;
        while (bus_phase != PH_IDLE) begin
            case (mode)
                RUN_LOW:  line = 1'b0;
                RUN_HIGH: line = 1'b1;
                default:  line = 1'($urandom_range(1));
            endcase
            push_tick(line);
        end
    endtask

    // hold the sender off until every result is back and the pipeline is empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // call only when settled
    task automatic load_regs();
        for (int r = 0; r < NUM_REGS; r++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(r);
            cfg_data <= cfg_plan[r];
            slot_len[r] = cfg_plan[r];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing pending", results_seen));
            end else begin
                want = pending_results.pop_front();
                if (got.drive_low !== want.drive_low)
                    flag_error($sformatf("result %0d drive_low %b want %b",
                                         results_seen, got.drive_low, want.drive_low));
                if (got.busy_res !== want.busy_res)
                    flag_error($sformatf("result %0d busy_res %b want %b",
                                         results_seen, got.busy_res, want.busy_res));
                if (got.done_res !== want.done_res)
                    flag_error($sformatf("result %0d done_res %b want %b",
                                         results_seen, got.done_res, want.done_res));
                if (got.presence !== want.presence)
                    flag_error($sformatf("result %0d presence %b want %b",
                                         results_seen, got.presence, want.presence));
                if (got.rx_byte !== want.rx_byte)
                    flag_error($sformatf("result %0d rx_byte %h want %h",
                                         results_seen, got.rx_byte, want.rx_byte));
                if (got.rejected !== want.rejected)
                    flag_error($sformatf("result %0d rejected %b want %b",
                                         results_seen, got.rejected, want.rejected));
            end
            if (got.done_res === 1'b1)
                ops_done++;
            if (got.rejected === 1'b1)
                starts_rejected++;
            results_seen++;
        end
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #(CLK_PERIOD * 4_000_000);
        $display("timeout with %0d results pending", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        t_item it;
        int    base;
        int    idle_plan [4];
        int    stall_plan [4];

        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;
        reset_model();

        // first rows run at the reset register values
        dir_rows = '{
            '{1'b0, 16'h0000, '{OP_TICK,  8'h00, 1'b1}, RUN_NONE, 1'b1, RES_IDLE},
            '{1'b0, 16'h0000, '{OP_READ,  8'h00, 1'b0}, RUN_NONE, 1'b1, RES_START},
            '{1'b0, 16'h0000, '{OP_WRITE, 8'hA5, 1'b0}, RUN_NONE, 1'b1, RES_REJ},
            '{1'b0, 16'h0000, '{OP_READ,  8'hFF, 1'b1}, RUN_NONE, 1'b1, RES_REJ},
            '{1'b0, 16'h0000, '{OP_RESET, 8'h00, 1'b1}, RUN_LOW,  1'b1, RES_REJ},
            '{1'b1, 16'h0000, '{OP_WRITE, 8'hFF, 1'b0}, RUN_RAND, 1'b0, RES_IDLE},
            '{1'b0, 16'h0000, '{OP_WRITE, 8'h00, 1'b1}, RUN_RAND, 1'b0, RES_IDLE},
            '{1'b0, 16'h0000, '{OP_READ,  8'h00, 1'b0}, RUN_HIGH, 1'b0, RES_IDLE},
            '{1'b0, 16'h0000, '{OP_READ,  8'hFF, 1'b1}, RUN_LOW,  1'b0, RES_IDLE},
            '{1'b0, 16'h0000, '{OP_RESET, 8'h00, 1'b0}, RUN_HIGH, 1'b0, RES_IDLE},
            '{1'b0, 16'h0000, '{OP_TICK,  8'hFF, 1'b0}, RUN_NONE, 1'b0, RES_IDLE},
            '{1'b1, 16'h0001, '{OP_READ,  8'h00, 1'b0}, RUN_RAND, 1'b0, RES_IDLE},
            '{1'b0, 16'h0001, '{OP_WRITE, 8'h5A, 1'b1}, RUN_RAND, 1'b0, RES_IDLE},
            '{1'b1, 16'h0020, '{OP_RESET, 8'h00, 1'b0}, RUN_RAND, 1'b0, RES_IDLE}
        };
        idle_plan  = '{0, 60, 0, 10};
        stall_plan = '{0, 0, 60, 10};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].reload) begin
                settle();
                foreach (cfg_plan[r])
                    cfg_plan[r] = dir_rows[n].reload_val;
                load_regs();
            end
            push_item(dir_rows[n].item, dir_rows[n].known, dir_rows[n].want);
            if (dir_rows[n].run != RUN_NONE)
                run_out(dir_rows[n].run);
        end
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = idle_plan[ph];
            stall_pct       = stall_plan[ph];
            // mostly short slots so that many operations fit
            foreach (cfg_plan[r])
                cfg_plan[r] = ($urandom_range(9) == 0) ? 16'($urandom_range(40))
                                                       : 16'($urandom_range(4));
            load_regs();
            base = items_counted;
            while (items_counted - base < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    it.op      = 2'($urandom_range(3, 1));
                    it.tx_byte = 8'($urandom_range(255));
                    it.line_in = 1'($urandom_range(1));
                    push_item(it, 1'b0, RES_IDLE);
                    while (bus_phase != PH_IDLE) begin
                        if ($urandom_range(99) < 3) begin
                            it.op      = 2'($urandom_range(3, 1));
                            it.tx_byte = 8'($urandom_range(255));
                            it.line_in = 1'($urandom_range(1));
                            push_item(it, 1'b0, RES_IDLE);
                        end else begin
                            push_tick(1'($urandom_range(1)));
                        end
                    end
                end else begin
                    it = t_item'($urandom_range(2047));
                    push_item(it, 1'b0, RES_IDLE);
                end
            end
            run_out(RUN_RAND);
            settle();
        end

        sender_idle_pct = 0;
        stall_pct       = 0;
        repeat (8) @(posedge i_clk);

        $display("%0d results checked over %0d counted items, directed rows plus 4 random phases",
                 results_seen, items_counted);
        $display("%0d operations completed, %0d starts rejected while busy",
                 ops_done, starts_rejected);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d results still pending", err_count, pending_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
